// ===== sv/fapcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fapcp_pkg
// Shared types and constants for the four-axis pulse-count positioner.
// ----------------------------------------------------------------------------
package fapcp_pkg;

    localparam int NUM_MOTORS     = 4;
    localparam int POSITION_WIDTH = 16;
    localparam int SAMPLE_WIDTH   = 10;
    localparam int MOTOR_SEL_W    = $clog2(NUM_MOTORS);
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int IDLE_CNT_W     = 3;

    // drive codes
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_CW  = 2'd1;
    localparam logic [1:0] DIR_CCW = 2'd2;

    // request codes
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_PRESET = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_M1A  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_M1B  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_M2A  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_M2B  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_DELAY  = 3'd5;

    localparam logic [SAMPLE_WIDTH-1:0] THRESHOLD_RESET  = 10'd800;
    localparam logic [IDLE_CNT_W-1:0]   IDLE_DELAY_RESET = 3'd5;

    typedef logic [POSITION_WIDTH-1:0] pos_t;

    typedef struct packed {
        logic                    req_type;
        logic [MOTOR_SEL_W-1:0]  motor_select;
        pos_t                    preset_value;
        logic                    opto_m1a;
        logic                    opto_m1b;
        logic [SAMPLE_WIDTH-1:0] sample_m2a;
        logic [SAMPLE_WIDTH-1:0] sample_m2b;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            drive_m1a;
        logic [1:0]            drive_m1b;
        logic [1:0]            drive_m2a;
        logic [1:0]            drive_m2b;
        logic [NUM_MOTORS-1:0] busy_mask;
        logic                  idle_event;
        pos_t                  pos_m1a;
        pos_t                  pos_m1b;
        pos_t                  pos_m2a;
        pos_t                  pos_m2b;
    } out_item_t;

    // per-axis state carried between the state registers and the axis logic
    typedef struct packed {
        pos_t       pos;
        logic [1:0] dir;
        logic       last_opto;
    } axis_state_t;

endpackage

// ===== sv/fapcp_axis.sv =====
// ----------------------------------------------------------------------------
// fapcp_axis
// One control tick for a single axis: direction choice, opto edge count, stop.
// ----------------------------------------------------------------------------
module fapcp_axis (
    input  fapcp_pkg::axis_state_t cur,
    input  fapcp_pkg::pos_t        target,
    input  logic                   opto_now,
    output fapcp_pkg::axis_state_t nxt
);

    logic [1:0]     dir_run;
    fapcp_pkg::pos_t pos_run;
    logic           rising;

    always_comb begin
        rising = !cur.last_opto && opto_now;

        // equal at tick start keeps the previous direction
        if (target != cur.pos) begin
            dir_run = (target < cur.pos) ? fapcp_pkg::DIR_CW : fapcp_pkg::DIR_CCW;
        end else begin
            dir_run = cur.dir;
        end

        pos_run = cur.pos;
        if (rising) begin
            case (dir_run)
                fapcp_pkg::DIR_CW:  pos_run = cur.pos - 1'b1;
                fapcp_pkg::DIR_CCW: pos_run = cur.pos + 1'b1;
                default:            pos_run = cur.pos;
            endcase
        end

        nxt.pos       = pos_run;
        nxt.dir       = (pos_run == target) ? fapcp_pkg::DIR_OFF : dir_run;
        nxt.last_opto = opto_now;
    end

endmodule

// ===== sv/four_axis_pulse_count_positioner_top.sv =====
// ----------------------------------------------------------------------------
// four_axis_pulse_count_positioner_top
// Bang-bang positioner for four motors driven by opto pulse counting.
// ----------------------------------------------------------------------------
//  channel | ports                              | beat
//  input   | s_valid s_ready s_data             | one tick or preset item
//  result  | m_valid m_ready m_data             | one result per input beat
//  config  | cfg_valid cfg_ready cfg_index/data | one register write
//
// An input beat is held in an input register, worked in one pass of axis
// logic and lands in the result register, one beat per cycle sustained while
// the result is taken. The axis state updates as the result register loads.
// A stalled result holds the pipeline; the input register still takes a beat
// while it is empty. Reset clears state, targets and both valid flags.
// ----------------------------------------------------------------------------
module four_axis_pulse_count_positioner_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  fapcp_pkg::in_item_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output fapcp_pkg::out_item_t                  m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fapcp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fapcp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int N = fapcp_pkg::NUM_MOTORS;

    // configuration
    fapcp_pkg::pos_t                      target_reg [N];
    logic [fapcp_pkg::SAMPLE_WIDTH-1:0]   threshold_reg;
    logic [fapcp_pkg::IDLE_CNT_W-1:0]     idle_delay_reg;

    // pipeline
    logic                  in_valid_reg;
    fapcp_pkg::in_item_t   in_reg;
    logic                  out_valid_reg;
    fapcp_pkg::out_item_t  out_reg;
    fapcp_pkg::out_item_t  out_next;
    logic                  advance;

    // axis state
    fapcp_pkg::axis_state_t axis_reg  [N];
    fapcp_pkg::axis_state_t axis_tick [N];
    fapcp_pkg::axis_state_t axis_next [N];
    logic [N-1:0]           opto_now;
    logic [N-1:0]           busy;
    logic [fapcp_pkg::IDLE_CNT_W-1:0] done_cnt_reg;
    logic [fapcp_pkg::IDLE_CNT_W-1:0] done_cnt_next;
    logic                   idle_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        opto_now[0] = in_reg.opto_m1a;
        opto_now[1] = in_reg.opto_m1b;
        opto_now[2] = in_reg.sample_m2a > threshold_reg;
        opto_now[3] = in_reg.sample_m2b > threshold_reg;
    end

    for (genvar m = 0; m < N; m++) begin : g_axis
        fapcp_axis u_axis (
            .cur      (axis_reg[m]),
            .target   (target_reg[m]),
            .opto_now (opto_now[m]),
            .nxt      (axis_tick[m])
        );
    end

    always_comb begin
        for (int m = 0; m < N; m++) begin
            if (in_reg.req_type == fapcp_pkg::REQ_PRESET) begin
                axis_next[m] = axis_reg[m];
                if (in_reg.motor_select == m[fapcp_pkg::MOTOR_SEL_W-1:0]) begin
                    axis_next[m].pos = in_reg.preset_value;
                end
            end else begin
                axis_next[m] = axis_tick[m];
            end
            busy[m] = axis_next[m].pos != target_reg[m];
        end

        done_cnt_next = done_cnt_reg;
        idle_next     = 1'b0;
        if (in_reg.req_type == fapcp_pkg::REQ_TICK && busy == '0) begin
            if (done_cnt_reg == idle_delay_reg) begin
                done_cnt_next = '0;
                idle_next     = 1'b1;
            end else begin
                done_cnt_next = done_cnt_reg + 1'b1;
            end
        end

        out_next.drive_m1a  = axis_next[0].dir;
        out_next.drive_m1b  = axis_next[1].dir;
        out_next.drive_m2a  = axis_next[2].dir;
        out_next.drive_m2b  = axis_next[3].dir;
        out_next.busy_mask  = busy;
        out_next.idle_event = idle_next;
        out_next.pos_m1a    = axis_next[0].pos;
        out_next.pos_m1b    = axis_next[1].pos;
        out_next.pos_m2a    = axis_next[2].pos;
        out_next.pos_m2b    = axis_next[3].pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < N; m++) begin
                target_reg[m] <= '0;
            end
            threshold_reg  <= fapcp_pkg::THRESHOLD_RESET;
            idle_delay_reg <= fapcp_pkg::IDLE_DELAY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                fapcp_pkg::REG_TARGET_M1A: target_reg[0] <= cfg_data;
                fapcp_pkg::REG_TARGET_M1B: target_reg[1] <= cfg_data;
                fapcp_pkg::REG_TARGET_M2A: target_reg[2] <= cfg_data;
                fapcp_pkg::REG_TARGET_M2B: target_reg[3] <= cfg_data;
                fapcp_pkg::REG_THRESHOLD:
                    threshold_reg <= cfg_data[fapcp_pkg::SAMPLE_WIDTH-1:0];
                fapcp_pkg::REG_IDLE_DELAY:
                    idle_delay_reg <= cfg_data[fapcp_pkg::IDLE_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            done_cnt_reg  <= '0;
            for (int m = 0; m < N; m++) begin
                axis_reg[m].pos       <= '0;
                axis_reg[m].dir       <= fapcp_pkg::DIR_OFF;
                axis_reg[m].last_opto <= 1'b0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                done_cnt_reg  <= done_cnt_next;
                for (int m = 0; m < N; m++) begin
                    axis_reg[m] <= axis_next[m];
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule
